FILE: design/tccw_pkg.sv
// tccw_pkg: shared constants, character codes and item types of the text console writer
// no dependencies; used by the top level, the checker, the scoreboard and the testbench
`default_nettype none

package tccw_pkg;

  // default screen geometry
  localparam int COLUMNS_DEF   = 80;
  localparam int ROWS_DEF      = 25;
  localparam int TAB_WIDTH_DEF = 8;

  // field widths
  localparam int CELL_W = 12;
  localparam int WORD_W = 16;
  localparam int BYTE_W = 8;

  // attribute of the blanks that a scroll puts in the last row
  localparam logic [BYTE_W-1:0] FILL_ATTRIBUTE = 8'h07;
  // reset value of the tab fill colour register
  localparam logic [BYTE_W-1:0] TAB_COLOR_RST  = 8'h07;
  localparam logic [BYTE_W-1:0] BLANK_CHAR     = 8'h20;
  localparam logic [WORD_W-1:0] BELL_MASK      = 16'hff00;

  // operation codes
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // control characters
  localparam logic [BYTE_W-1:0] CH_BEL = 8'h07;
  localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
  localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF  = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_VT  = 8'h0b;
  localparam logic [BYTE_W-1:0] CH_CR  = 8'h0d;

  typedef struct packed {
    logic              operation;
    logic [BYTE_W-1:0] char_code;
    logic [BYTE_W-1:0] color;
    logic [CELL_W-1:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] cell_word;
    logic [CELL_W-1:0] cursor_cell;
  } out_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] tab_fill_color;
  } cfg_item_t;

endpackage

`default_nettype wire

FILE: design/tccw_chan_if.sv
// tccw_chan_if: valid/ready channel carrying one item of type T
// no dependencies; payload types come from tccw_pkg at the instance
`default_nettype none

interface tccw_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source  (output valid, output data, input ready);
  modport sink    (input valid, input data, output ready);
  modport monitor (input valid, input ready, input data);
endinterface

`default_nettype wire

FILE: design/tccw_ram.sv
// tccw_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/text_console_char_writer.sv
// text_console_char_writer: text console cell store with cursor, scrolling and control codes
// depends on tccw_pkg, tccw_chan_if and tccw_ram
//
//   channel   direction  item             handshake
//   in_if     sink       in_item_t        valid & ready
//   out_if    source     out_item_t       valid & ready
//   cfg_if    sink       cfg_item_t       valid & ready (ready always high)
//
// one item at a time; a tab writes its blanks one cell after another, a bell reads the cell
// and writes it back with the attribute byte flipped, an out-of-range read goes straight to the result
// a scroll copies every row up through the single cell ram, then blanks the last row
// after reset a clearing pass writes zero to all COLUMNS*ROWS cells, no item taken meanwhile
// a finished result waits in the output register; the next item is taken meanwhile
`default_nettype none

module text_console_char_writer #(
  parameter int COLUMNS   = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS      = tccw_pkg::ROWS_DEF,
  parameter int TAB_WIDTH = tccw_pkg::TAB_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tccw_chan_if.sink   in_if,
  tccw_chan_if.source out_if,
  tccw_chan_if.sink   cfg_if
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int LRS        = CELL_COUNT - COLUMNS;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int CUR_W      = $clog2(CELL_COUNT + TAB_WIDTH * COLUMNS + 1);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int TPH_W      = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
  localparam int TL_W       = $clog2(TAB_WIDTH + 1);
  localparam int LAST_TPH   = (COLUMNS - 1) % TAB_WIDTH;
  localparam int WW         = tccw_pkg::WORD_W;
  localparam int BW         = tccw_pkg::BYTE_W;

  localparam logic [AW-1:0]    A_LAST   = AW'(CELL_COUNT - 1);
  localparam logic [AW-1:0]    A_LRS    = AW'(LRS);
  localparam logic [AW-1:0]    A_COLS   = AW'(COLUMNS);
  localparam logic [CUR_W-1:0] C_COUNT  = CUR_W'(CELL_COUNT);
  localparam logic [CUR_W-1:0] C_LRS    = CUR_W'(LRS);
  localparam logic [CUR_W-1:0] C_COLS   = CUR_W'(COLUMNS);
  localparam logic [CUR_W-1:0] C_VT     = CUR_W'(TAB_WIDTH * COLUMNS);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
  localparam logic [TPH_W-1:0] TPH_LAST = TPH_W'(TAB_WIDTH - 1);
  localparam logic [TPH_W-1:0] TPH_WRAP = TPH_W'(LAST_TPH);
  localparam logic [TL_W-1:0]  TL_FULL  = TL_W'(TAB_WIDTH);

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_PUT    = 4'd2;
  localparam logic [3:0] ST_SCROLL = 4'd3;
  localparam logic [3:0] ST_FILL   = 4'd4;
  localparam logic [3:0] ST_TAB    = 4'd5;
  localparam logic [3:0] ST_BELL   = 4'd6;
  localparam logic [3:0] ST_READ   = 4'd7;
  localparam logic [3:0] ST_DONE   = 4'd8;

  logic [3:0]       state_q, state_d;
  logic [AW-1:0]    sc_q, sc_d;
  logic             pend_q, pend_d;
  logic [AW-1:0]    wa_q, wa_d;
  logic             ret_tab_q, ret_tab_d;
  logic [CUR_W-1:0] cursor_q, cursor_d;
  logic [CUR_W-1:0] rowst_q, rowst_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [TPH_W-1:0] tph_q, tph_d;
  logic [TL_W-1:0]  tab_left_q, tab_left_d;
  logic [BW-1:0]    ch_q, ch_d;
  logic [BW-1:0]    attr_q, attr_d;
  logic [WW-1:0]    word_q, word_d;
  logic [BW-1:0]    tab_color_q;
  logic             out_valid_q;
  tccw_pkg::out_item_t out_item_q;

  // ram ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [WW-1:0] ram_rdata;

  // cursor advance by one cell
  logic [CUR_W-1:0] cur_adv, rowst_adv;
  logic [COL_W-1:0] col_adv;
  logic [TPH_W-1:0] tph_adv;

  logic          in_acc;
  logic          out_free;
  logic          at_end;
  logic [AW-1:0] cur_addr;
  logic [31:0]   idx_ext;
  logic [31:0]   cur_ext;

  assign in_acc   = in_if.valid && in_if.ready;
  assign out_free = !out_valid_q || out_if.ready;
  assign at_end   = (cursor_q >= C_COUNT);
  assign cur_addr = cursor_q[AW-1:0];
  assign idx_ext  = 32'(in_if.data.cell_index);
  assign cur_ext  = 32'(cursor_q);

  assign in_if.ready  = (state_q == ST_IDLE);
  assign cfg_if.ready = 1'b1;

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_item_q;

  // one-cell advance with row wrap
  always_comb begin
    cur_adv = cursor_q + CUR_W'(1);
    if (col_q == COL_LAST) begin
      col_adv   = '0;
      rowst_adv = rowst_q + C_COLS;
      tph_adv   = '0;
    end else begin
      col_adv   = col_q + COL_W'(1);
      rowst_adv = rowst_q;
      tph_adv   = (tph_q == TPH_LAST) ? '0 : tph_q + TPH_W'(1);
    end
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    sc_d       = sc_q;
    pend_d     = 1'b0;
    wa_d       = wa_q;
    ret_tab_d  = ret_tab_q;
    cursor_d   = cursor_q;
    rowst_d    = rowst_q;
    col_d      = col_q;
    tph_d      = tph_q;
    tab_left_d = tab_left_q;
    ch_d       = ch_q;
    attr_d     = attr_q;
    word_d     = word_q;
    ram_we     = 1'b0;
    ram_waddr  = cur_addr;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = cur_addr;

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = sc_q;
        ram_wdata = '0;
        if (sc_q == A_LAST) begin
          sc_d    = '0;
          state_d = ST_IDLE;
        end else begin
          sc_d = sc_q + AW'(1);
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          ch_d   = in_if.data.char_code;
          attr_d = in_if.data.color;
          word_d = '0;
          if (in_if.data.operation == tccw_pkg::OP_READ) begin
            if (idx_ext < 32'(CELL_COUNT)) begin
              ram_re    = 1'b1;
              ram_raddr = idx_ext[AW-1:0];
              state_d   = ST_READ;
            end else begin
              state_d = ST_DONE;
            end
          end else begin
            state_d = ST_PUT;
          end
        end
      end

      ST_READ: begin
        word_d  = ram_rdata;
        state_d = ST_DONE;
      end

      ST_PUT: begin
        if (at_end) begin
          // scroll before the character
          state_d   = ST_SCROLL;
          sc_d      = '0;
          ret_tab_d = 1'b0;
          cursor_d  = C_LRS;
          rowst_d   = C_LRS;
          col_d     = '0;
          tph_d     = '0;
        end else begin
          state_d = ST_DONE;
          case (ch_q)
            tccw_pkg::CH_CR: begin
              cursor_d = rowst_q;
              col_d    = '0;
              tph_d    = '0;
            end
            tccw_pkg::CH_LF: begin
              cursor_d = rowst_q + C_COLS;
              rowst_d  = rowst_q + C_COLS;
              col_d    = '0;
              tph_d    = '0;
            end
            tccw_pkg::CH_VT: begin
              cursor_d = rowst_q + C_VT;
              rowst_d  = rowst_q + C_VT;
              col_d    = '0;
              tph_d    = '0;
            end
            tccw_pkg::CH_BS: begin
              if (cursor_q != '0) begin
                cursor_d = cursor_q - CUR_W'(1);
                if (col_q == '0) begin
                  col_d   = COL_LAST;
                  rowst_d = rowst_q - C_COLS;
                  tph_d   = TPH_WRAP;
                end else begin
                  col_d = col_q - COL_W'(1);
                  tph_d = (tph_q == '0) ? TPH_LAST : tph_q - TPH_W'(1);
                end
              end
            end
            tccw_pkg::CH_TAB: begin
              tab_left_d = TL_FULL - TL_W'(tph_q);
              state_d    = ST_TAB;
            end
            tccw_pkg::CH_BEL: begin
              ram_re    = 1'b1;
              ram_raddr = cur_addr;
              state_d   = ST_BELL;
            end
            default: begin
              ram_we    = 1'b1;
              ram_waddr = cur_addr;
              ram_wdata = {attr_q, ch_q};
              cursor_d  = cur_adv;
              rowst_d   = rowst_adv;
              col_d     = col_adv;
              tph_d     = tph_adv;
            end
          endcase
        end
      end

      ST_TAB: begin
        if (tab_left_q == '0) begin
          state_d = ST_DONE;
        end else if (at_end) begin
          // scroll before this blank
          state_d   = ST_SCROLL;
          sc_d      = '0;
          ret_tab_d = 1'b1;
          cursor_d  = C_LRS;
          rowst_d   = C_LRS;
          col_d     = '0;
          tph_d     = '0;
        end else begin
          ram_we     = 1'b1;
          ram_waddr  = cur_addr;
          ram_wdata  = {tab_color_q, tccw_pkg::BLANK_CHAR};
          cursor_d   = cur_adv;
          rowst_d    = rowst_adv;
          col_d      = col_adv;
          tph_d      = tph_adv;
          tab_left_d = tab_left_q - TL_W'(1);
          if (tab_left_q == TL_W'(1)) begin
            state_d = ST_DONE;
          end
        end
      end

      ST_SCROLL: begin
        // read one row below, write back the word of the previous read
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = wa_q;
          ram_wdata = ram_rdata;
        end
        if (sc_q < A_LRS) begin
          ram_re    = 1'b1;
          ram_raddr = sc_q + A_COLS;
          pend_d    = 1'b1;
          wa_d      = sc_q;
          sc_d      = sc_q + AW'(1);
        end else begin
          state_d = ST_FILL;
        end
      end

      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = sc_q;
        ram_wdata = {tccw_pkg::FILL_ATTRIBUTE, tccw_pkg::BLANK_CHAR};
        if (sc_q == A_LAST) begin
          sc_d    = '0;
          state_d = ret_tab_q ? ST_TAB : ST_PUT;
        end else begin
          sc_d = sc_q + AW'(1);
        end
      end

      ST_BELL: begin
        ram_we    = 1'b1;
        ram_waddr = cur_addr;
        ram_wdata = ram_rdata ^ tccw_pkg::BELL_MASK;
        state_d   = ST_DONE;
      end

      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      sc_q       <= '0;
      pend_q     <= 1'b0;
      ret_tab_q  <= 1'b0;
      cursor_q   <= '0;
      rowst_q    <= '0;
      col_q      <= '0;
      tph_q      <= '0;
      tab_left_q <= '0;
    end else begin
      state_q    <= state_d;
      sc_q       <= sc_d;
      pend_q     <= pend_d;
      ret_tab_q  <= ret_tab_d;
      cursor_q   <= cursor_d;
      rowst_q    <= rowst_d;
      col_q      <= col_d;
      tph_q      <= tph_d;
      tab_left_q <= tab_left_d;
    end
  end

  // item payload
  always_ff @(posedge clk_i) begin
    wa_q   <= wa_d;
    ch_q   <= ch_d;
    attr_q <= attr_d;
    word_q <= word_d;
  end

  // tab fill colour register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_color_q <= tccw_pkg::TAB_COLOR_RST;
    end else if (cfg_if.valid && cfg_if.ready) begin
      tab_color_q <= cfg_if.data.tab_fill_color;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_item_q.cell_word   <= word_q;
      out_item_q.cursor_cell <= cur_ext[tccw_pkg::CELL_W-1:0];
    end
  end

  // cell store
  tccw_ram #(
    .WIDTH (WW),
    .DEPTH (CELL_COUNT)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

FILE: design/tccw_checker.sv
// tccw_checker: port-level assertions for the text console writer, bound to the top level
// depends on tccw_pkg for the result item type
`default_nettype none

module tccw_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input tccw_pkg::out_item_t out_data_i
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] open_q, open_d;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // items taken and not yet delivered
  always_comb begin
    open_d = open_q;
    if (in_acc && !out_acc) begin
      open_d = open_q + 2'd1;
    end else if (!in_acc && out_acc) begin
      open_d = open_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_d;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result dropped or changed while stalled");

  // no more than one item at work and one waiting at the output
  a_in_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> open_q != 2'd2)
    else $error("item taken with no room");

  // no result without an open item
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> open_q != 2'd0)
    else $error("result without an item");

  // one item at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("item taken on consecutive cycles");

endmodule

bind text_console_char_writer tccw_checker u_tccw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_data_i  (out_if.data)
);

`default_nettype wire

FILE: tb/sv/tccw_scoreboard_pkg.sv
// tccw_scoreboard_pkg: screen and cursor tracker that predicts and checks console results
// depends on tccw_pkg for item types, character codes and screen geometry
package tccw_scoreboard_pkg;

  import tccw_pkg::*;

  localparam int unsigned SCREEN_CELLS   = COLUMNS_DEF * ROWS_DEF;
  localparam int unsigned LAST_ROW_START = SCREEN_CELLS - COLUMNS_DEF;

  class console_scoreboard;

    logic [WORD_W-1:0] screen [SCREEN_CELLS];
    int unsigned       cursor;
    logic [BYTE_W-1:0] tab_color;
    out_item_t         awaited_q [$];
    int unsigned       errors;

    function new();
      foreach (screen[i]) screen[i] = '0;
      cursor    = 0;
      tab_color = TAB_COLOR_RST;
      errors    = 0;
    endfunction

    function void set_tab_color(logic [BYTE_W-1:0] colour);
      tab_color = colour;
    endfunction

    function int unsigned pending();
      return awaited_q.size();
    endfunction

    // move all rows up by one once the cursor has run off the screen
    function void scroll_when_full();
      if (cursor < SCREEN_CELLS) return;
      for (int unsigned i = 0; i < LAST_ROW_START; i++) screen[i] = screen[i + COLUMNS_DEF];
      for (int unsigned i = LAST_ROW_START; i < SCREEN_CELLS; i++) begin
        screen[i] = {FILL_ATTRIBUTE, BLANK_CHAR};
      end
      cursor = LAST_ROW_START;
    endfunction

    // control codes or a plain character at the cursor
    function void put_char(logic [BYTE_W-1:0] ch, logic [BYTE_W-1:0] attr);
      int unsigned line_start;
      int unsigned blanks;
      scroll_when_full();
      line_start = cursor - (cursor % COLUMNS_DEF);
      case (ch)
        CH_CR: cursor = line_start;
        CH_LF: cursor = line_start + COLUMNS_DEF;
        CH_BS: begin
          if (cursor > 0) cursor--;
        end
        CH_TAB: begin
          // blank count fixed up front, each blank may still scroll
          blanks = TAB_WIDTH_DEF - ((cursor % COLUMNS_DEF) % TAB_WIDTH_DEF);
          repeat (blanks) begin
            scroll_when_full();
            screen[cursor] = {tab_color, BLANK_CHAR};
            cursor++;
          end
        end
        CH_VT: cursor = line_start + TAB_WIDTH_DEF * COLUMNS_DEF;
        CH_BEL: screen[cursor] = screen[cursor] ^ BELL_MASK;
        default: begin
          screen[cursor] = {attr, ch};
          cursor++;
        end
      endcase
    endfunction

    // work out the result of an accepted item and queue it
    function void note_item(in_item_t it);
      out_item_t exp;
      exp.cell_word = '0;
      if (it.operation == OP_READ) begin
        if (it.cell_index < SCREEN_CELLS) exp.cell_word = screen[it.cell_index];
      end else begin
        put_char(it.char_code, it.color);
      end
      exp.cursor_cell = cursor[CELL_W-1:0];
      awaited_q.push_back(exp);
    endfunction

    // compare an accepted result with the oldest prediction
    function void check_result(out_item_t got);
      out_item_t exp;
      if (awaited_q.size() == 0) begin
        $error("unexpected result: cell_word %h cursor_cell %0d", got.cell_word,
               got.cursor_cell);
        errors++;
        return;
      end
      exp = awaited_q.pop_front();
      if (got.cell_word !== exp.cell_word) begin
        $error("cell_word: expected %h, actual %h", exp.cell_word, got.cell_word);
        errors++;
      end
      if (got.cursor_cell !== exp.cursor_cell) begin
        $error("cursor_cell: expected %0d, actual %0d", exp.cursor_cell, got.cursor_cell);
        errors++;
      end
    endfunction

  endclass

endpackage

FILE: tb/sv/text_console_char_writer_tb.sv
// text_console_char_writer_tb: drives puts, reads and tab colour writes into the console writer
// depends on tccw_pkg, tccw_chan_if, tccw_scoreboard_pkg and the text_console_char_writer rtl
module text_console_char_writer_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import tccw_pkg::*;
  import tccw_scoreboard_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic steady_run;
  logic hold_req;

  console_scoreboard sb;

  tccw_chan_if #(.T(in_item_t))  in_if ();
  tccw_chan_if #(.T(out_item_t)) out_if ();
  tccw_chan_if #(.T(cfg_item_t)) cfg_if ();

  text_console_char_writer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // offer one item, with random idle cycles before it unless steady
  task automatic offer(input in_item_t it, input bit steady);
    if (!steady) begin
      while ($urandom_range(99) < 36) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send_put(input logic [BYTE_W-1:0] ch, input logic [BYTE_W-1:0] attr);
    offer('{operation: OP_PUT, char_code: ch, color: attr, cell_index: '0}, 1'b0);
  endtask

  task automatic send_read(input logic [CELL_W-1:0] idx);
    offer('{operation: OP_READ, char_code: '0, color: '0, cell_index: idx}, 1'b0);
  endtask

  task automatic write_tab_color(input logic [BYTE_W-1:0] colour);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= cfg_item_t'{tab_fill_color: colour};
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // wait until every predicted result has come back, then let the block settle
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // random item: mostly plain characters and reads, control codes weighted up
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick;
    it.operation  = OP_PUT;
    it.char_code  = $urandom_range(255);
    it.color      = $urandom_range(255);
    it.cell_index = $urandom_range(4095);
    pick = $urandom_range(99);
    if (pick < 30) begin
      it.operation = OP_READ;
      if ($urandom_range(99) < 85) it.cell_index = $urandom_range(SCREEN_CELLS - 1);
    end else if (pick < 38) begin
      it.char_code = CH_LF;
    end else if (pick < 42) begin
      it.char_code = CH_VT;
    end else if (pick < 47) begin
      it.char_code = CH_TAB;
    end else if (pick < 51) begin
      it.char_code = CH_CR;
    end else if (pick < 55) begin
      it.char_code = CH_BS;
    end else if (pick < 60) begin
      it.char_code = CH_BEL;
    end
    return it;
  endfunction

  // handshake monitor feeding the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && cfg_if.valid && cfg_if.ready) sb.set_tab_color(cfg_if.data.tab_fill_color);
    if (rst_ni && in_if.valid && in_if.ready) sb.note_item(in_if.data);
    if (rst_ni && out_if.valid && out_if.ready) sb.check_result(out_if.data);
  end

  // result side: random stalls, a steady stretch and one long hold-off
  initial begin : result_sink
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_left = 2500;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (steady_run) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= 36);
      end
    end
  end

  // main sequence
  initial begin : stimulus
    logic [BYTE_W-1:0] phase_colors [4];
    bit                steady;
    sb = new();
    phase_colors = '{8'hff, 8'h00, 8'($urandom_range(1, 254)), 8'($urandom_range(255))};
    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    out_if.ready <= 1'b0;
    steady_run   <= 1'b0;
    hold_req     <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed items with the tab colour at its reset value
    send_put(CH_BS, 8'h00);          // backspace at cell zero stays put
    send_read(12'd0);                // store cleared after reset
    send_put(8'h41, 8'hff);
    send_put(8'h00, 8'h00);
    send_put(8'hff, 8'h80);
    send_put(CH_BS, 8'h00);
    send_put(CH_BEL, 8'h00);         // flip the attribute under the cursor
    send_read(12'd2);
    send_put(CH_TAB, 8'h00);
    send_read(12'd7);
    send_put(CH_CR, 8'h00);
    send_put(CH_LF, 8'h00);
    send_read(12'hfff);              // past the screen end reads zero
    send_read(12'(SCREEN_CELLS - 1));
    send_read(12'(SCREEN_CELLS));
    send_put(CH_VT, 8'h00);
    send_put(CH_VT, 8'h00);
    send_put(CH_VT, 8'h00);          // lands exactly on the screen end
    send_put(CH_VT, 8'h00);          // scrolls, then jumps far past the end
    send_put(8'h5a, 8'h1e);          // only one row scrolls
    send_read(12'(LAST_ROW_START));
    send_read(12'(LAST_ROW_START - 1));
    send_put(CH_TAB, 8'h00);
    send_put(CH_LF, 8'h00);
    send_put(CH_TAB, 8'h00);         // scroll before the tab blanks
    drain();

    // random phases, one tab colour each
    for (int p = 0; p < 4; p++) begin
      write_tab_color(phase_colors[p]);
      for (int k = 0; k < 260; k++) begin
        steady = (p == 1) && (k >= 40) && (k < 200);
        steady_run <= steady;
        if (p == 2 && k == 30) hold_req <= 1'b1;
        offer(random_item(), steady);
      end
      drain();
    end

    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("text_console_char_writer test passed");
    end else begin
      $display("text_console_char_writer test failed");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #50ms;
    $display("text_console_char_writer test failed");
    $finish;
  end

endmodule
